>>> sv/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and segment decoding for the seven-segment
// serial driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int DIGIT_COUNT_DEF = 3;
  localparam int BITS_PER_DIGIT  = 8;
  localparam int NUMBER_W        = 10;
  localparam int QUEUE_DEPTH     = 2;
  localparam logic [NUMBER_W-1:0] NUMBER_LIMIT = 10'd999;

  typedef enum logic [1:0] {
    KIND_SHOW,
    KIND_BLANK,
    KIND_ERROR
  } ssd_kind_t;

  typedef struct packed {
    ssd_kind_t           kind;
    logic [NUMBER_W-1:0] number;
  } ssd_cmd_t;

  typedef struct packed {
    logic     valid;
    ssd_cmd_t cmd;
  } ssd_req_t;

  // active-low register image, bit 0 = QA, QH kept dark
  function automatic logic [BITS_PER_DIGIT-1:0] seg_image(input logic [3:0] digit);
    logic [6:0] lit;
    unique case (digit)
      4'd0:    lit = 7'h3F;
      4'd1:    lit = 7'h30;
      4'd2:    lit = 7'h5B;
      4'd3:    lit = 7'h4F;
      4'd4:    lit = 7'h66;
      4'd5:    lit = 7'h6D;
      4'd6:    lit = 7'h7D;
      4'd7:    lit = 7'h07;
      4'd8:    lit = 7'h7F;
      4'd9:    lit = 7'h67;
      default: lit = 7'h00;
    endcase
    return {1'b1, ~lit};
  endfunction

endpackage

>>> sv/ssd_front.sv
// ----------------------------------------------------------------------------
// ssd_front
// Accepts display requests, classifies them and holds them in a short
// queue for the serialiser.
// ----------------------------------------------------------------------------
module ssd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_req_type,
  input  logic [ssd_pkg::NUMBER_W-1:0]  in_number,
  output ssd_pkg::ssd_req_t             req,
  input  logic                          take
);

  localparam int PTR_W = (ssd_pkg::QUEUE_DEPTH > 1) ? $clog2(ssd_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ssd_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(ssd_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(ssd_pkg::QUEUE_DEPTH - 1);

  ssd_pkg::ssd_cmd_t  entry_r [ssd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  ssd_pkg::ssd_cmd_t  cmd_in;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    cmd_in.number = in_number;
    if (in_req_type) begin
      cmd_in.kind = ssd_pkg::KIND_BLANK;
    end else if (in_number > ssd_pkg::NUMBER_LIMIT) begin
      cmd_in.kind = ssd_pkg::KIND_ERROR;
    end else begin
      cmd_in.kind = ssd_pkg::KIND_SHOW;
    end
  end

  assign full      = (count_r == DEPTH_CNT);
  assign do_push   = push && !full;
  assign do_pop    = take && (count_r != '0);
  assign req.valid = (count_r != '0);
  assign req.cmd   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_r <= CNT_W'(count_r + 1'b1);
      end else if (do_pop && !do_push) begin
        count_r <= CNT_W'(count_r - 1'b1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("queue count beyond depth");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> req.valid)
    else $error("take from empty queue");

endmodule

>>> sv/ssd_back.sv
// ----------------------------------------------------------------------------
// ssd_back
// Splits the number one decimal digit at a time and shifts the active-low
// register images out bit by bit into the result register.
// ----------------------------------------------------------------------------
module ssd_back #(
  parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ssd_pkg::ssd_req_t req,
  output logic              take,
  output logic              empty,
  input  logic              pop,
  output logic              out_serial_bit,
  output logic              out_shift_valid,
  output logic              out_latch,
  output logic              out_range_error
);

  localparam int BPD   = ssd_pkg::BITS_PER_DIGIT;
  localparam int NW    = ssd_pkg::NUMBER_W;
  localparam int BIT_W = $clog2(BPD);
  localparam int DIG_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [BIT_W-1:0] LAST_BIT   = BIT_W'(BPD - 1);
  localparam logic [DIG_W-1:0] LAST_DIGIT = DIG_W'(DIGIT_COUNT - 1);

  logic              busy_r;
  logic              blank_r;
  logic [NW-1:0]     value_r;
  logic [BPD-1:0]    img_r;
  logic [BIT_W-1:0]  bit_r;
  logic [DIG_W-1:0]  digit_r;
  logic              out_valid_r;
  logic              out_serial_bit_r;
  logic              out_shift_valid_r;
  logic              out_latch_r;
  logic              out_range_error_r;

  logic              advance;
  logic              fin;
  logic              is_err;
  logic [NW-1:0]     src;
  logic              src_blank;
  logic [17:0]       prod;
  logic [NW-1:0]     quot;
  logic [3:0]        rem_digit;
  logic [BPD-1:0]    img_next;

  assign advance = !out_valid_r || pop;
  assign fin     = busy_r && (bit_r == LAST_BIT) && (digit_r == LAST_DIGIT);
  assign is_err  = (req.cmd.kind == ssd_pkg::KIND_ERROR);
  assign take    = req.valid && advance && (!busy_r || (fin && !is_err));

  // divide by ten through the reciprocal 205/2048, exact below 1029
  always_comb begin
    src       = take ? req.cmd.number : value_r;
    src_blank = take ? (req.cmd.kind == ssd_pkg::KIND_BLANK) : blank_r;
    prod      = 18'(src) * 18'd205;
    quot      = NW'(prod >> 11);
    rem_digit = 4'(src - {quot[NW-4:0], 3'b000} - {quot[NW-2:0], 1'b0});
    img_next  = src_blank ? '1 : ssd_pkg::seg_image(rem_digit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      bit_r       <= '0;
      digit_r     <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= busy_r || (take && is_err);
        if (busy_r) begin
          out_serial_bit_r  <= img_r[bit_r];
          out_shift_valid_r <= 1'b1;
          out_latch_r       <= fin;
          out_range_error_r <= 1'b0;
        end else begin
          out_serial_bit_r  <= 1'b0;
          out_shift_valid_r <= 1'b0;
          out_latch_r       <= 1'b0;
          out_range_error_r <= 1'b1;
        end
      end
      if (take && !is_err) begin
        busy_r  <= 1'b1;
        blank_r <= src_blank;
        bit_r   <= '0;
        digit_r <= '0;
        img_r   <= img_next;
        value_r <= quot;
      end else if (busy_r && advance) begin
        if (bit_r == LAST_BIT) begin
          bit_r   <= '0;
          digit_r <= DIG_W'(digit_r + 1'b1);
          img_r   <= img_next;
          value_r <= quot;
          if (digit_r == LAST_DIGIT) begin
            busy_r <= 1'b0;
          end
        end else begin
          bit_r <= BIT_W'(bit_r + 1'b1);
        end
      end
    end
  end

  assign empty           = !out_valid_r;
  assign out_serial_bit  = out_serial_bit_r;
  assign out_shift_valid = out_shift_valid_r;
  assign out_latch       = out_latch_r;
  assign out_range_error = out_range_error_r;

  a_no_take_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !fin) |-> !take)
    else $error("request taken in the middle of a frame");

  a_error_not_shifted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_range_error_r) |-> (!out_shift_valid_r && !out_latch_r))
    else $error("error result marked as shifted");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && advance) |=> (out_valid_r && out_latch_r))
    else $error("last frame bit without latch flag");

  a_latch_shifted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_latch_r) |-> out_shift_valid_r)
    else $error("latch flag on unshifted result");

endmodule

>>> sv/seven_segment_serial_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_serial_driver
// Display requests in, one serial shift-register bit per result out.
// From idle, a display or blank request is loaded into the serialiser before
// its first bit is registered; an out-of-range request is registered as an
// error result when taken. The one-bit-per-cycle serialiser, held while a
// result waits for pop, shifts DIGIT_COUNT images of eight bits per request;
// a frame that starts from idle adds a load step, an error takes one result.
// Reset: synchronous, clears queue, serialiser state and output valid flag.
// ----------------------------------------------------------------------------
module seven_segment_serial_driver #(
  parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_req_type,
  input  logic [ssd_pkg::NUMBER_W-1:0] in_number,
  output logic                         empty,
  input  logic                         pop,
  output logic                         out_serial_bit,
  output logic                         out_shift_valid,
  output logic                         out_latch,
  output logic                         out_range_error
);

  ssd_pkg::ssd_req_t req;
  logic              take;

  ssd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_req_type (in_req_type),
    .in_number   (in_number),
    .req         (req),
    .take        (take)
  );

  ssd_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .take            (take),
    .empty           (empty),
    .pop             (pop),
    .out_serial_bit  (out_serial_bit),
    .out_shift_valid (out_shift_valid),
    .out_latch       (out_latch),
    .out_range_error (out_range_error)
  );

endmodule
